// ----- design/topf_pkg.sv -----
// Shared widths, command codes and status codes for the tour two-opt flip unit.
// No dependencies.
package topf_pkg;

	localparam int unsigned MAX_NODES_DEF = 1024;

	localparam int NODE_W   = 10;
	localparam int CNT_W    = 11;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FLIP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_FLIP_DONE = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOOP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_READ      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LOAD      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_ADJ   = 3'd4;

	// Smallest tour the node counter is clamped to
	localparam cnt_t MIN_COUNT = 11'd3;

endpackage

// ----- design/tour_two_opt_flip_unit.sv -----
// Top level of the tour two-opt flip unit: link and rank stores plus the
// sequencer that loads, reads and performs two-opt moves. Uses topf_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transfer:
//   load a node entry, read a node entry, or a two-opt flip of t1,t2,t3.
//   Output channel (out_valid/out_stall) returns one result per load, read
//   or flip; command code 3 is dropped and gives no result.
//   Configuration channel (cfg_valid/cfg_ready) writes node_count; it is
//   always ready; the user must write it only while the unit is idle, unchecked.
// Flip walk and stall:
//   A performed flip walks L nodes, L being the number of nodes of the
//   shorter segment (at most half the clamped node count on a consistent
//   tour, never more than the clamped node count): the walk handles one node
//   a cycle through the single read and single write port of each store.
//   in_stall is high from acceptance until the result is placed in the
//   output register, so one command is in work at a time.
// Reset:
//   arst_n clears the sequencer and the output valid, sets node_count to 1024.
//   Stores are not cleared; the user must load entries before use (unchecked).
// Back-pressure:
//   A result waits in the output register while out_stall is high; the next
//   command is still taken and holds in its final step until the output
//   register frees up.
module tour_two_opt_flip_unit
	import topf_pkg::*;
#(
	parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Command channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  node_t               first_node,
	input  node_t               second_node,
	input  node_t               third_node,
	input  node_t               entry_pred,
	input  node_t               entry_succ,
	input  node_t               entry_rank,
	// Result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output node_t               end_a,
	output node_t               end_b,
	output node_t               end_c,
	output node_t               end_d,
	output node_t               read_pred,
	output node_t               read_succ,
	output node_t               read_rank,
	// Configuration channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cnt_t                cfg_data
);

	localparam int AW = $clog2(MAX_NODES);

	typedef logic [AW-1:0] addr_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_ADDR,
		S_RD_DATA,
		S_T1,
		S_T2,
		S_T3,
		S_T4,
		S_RK_B,
		S_RK_C,
		S_CMP,
		S_RK_A,
		S_START,
		S_WALK,
		S_LINK1,
		S_LINK2,
		S_DONE
	} state_t;

	// Reduce a node number into the store range by shifted compare-subtract
	function automatic node_t node_idx(input node_t v);
		logic [31:0] r;
		r = 32'(v);
		if (MAX_NODES < (1 << NODE_W)) begin
			for (int k = 7; k >= 0; k--) begin
				if (r >= (32'(MAX_NODES) << k)) begin
					r = r - (32'(MAX_NODES) << k);
				end
			end
		end
		return r[NODE_W-1:0];
	endfunction

	// Stores
	node_t pred_mem [MAX_NODES];
	node_t succ_mem [MAX_NODES];
	node_t rank_mem [MAX_NODES];

	node_t pred_rd_q, succ_rd_q, rank_rd_q;

	addr_t rd_addr;
	logic  pred_we, succ_we, rank_we;
	addr_t pred_wa, succ_wa, rank_wa;
	node_t pred_wd, succ_wd, rank_wd;

	// Sequencer registers
	state_t state_q;
	cnt_t   node_count_q;
	node_t  ta_q, tb_q, tc_q;
	node_t  a_q, b_q, c_q, d_q;
	node_t  p1_q, s1_q;
	node_t  rb_q;
	node_t  s_q;
	cnt_t   i_q;
	cnt_t   nr_q;
	logic [STATUS_W-1:0] res_status_q;
	node_t  rp_q, rs_q, rr_q;

	// Output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	node_t               end_a_q, end_b_q, end_c_q, end_d_q;
	node_t               read_pred_q, read_succ_q, read_rank_q;

	cnt_t              n_c;
	logic signed [12:0] drank_c;
	logic              swap_c;
	logic              walk_done_c;
	node_t             p2_c, s2_c, t4_c;
	logic              adj_c, noop_c;

	// Clamp the node count to 3..MAX_NODES
	always_comb begin
		if (node_count_q < MIN_COUNT) begin
			n_c = MIN_COUNT;
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_c = CNT_W'(MAX_NODES);
		end else begin
			n_c = node_count_q;
		end
	end

	// Neighbor checks, t4 and segment choice
	always_comb begin
		p2_c   = node_idx(pred_rd_q);
		s2_c   = node_idx(succ_rd_q);
		adj_c  = (p1_q == tb_q) || (s1_q == tb_q);
		noop_c = (tc_q == p2_c) || (tc_q == s2_c);
		t4_c   = (s1_q == tb_q) ? node_idx(pred_rd_q) : node_idx(succ_rd_q);

		drank_c = $signed({3'b000, rb_q}) - $signed({3'b000, rank_rd_q});
		if (drank_c < 0) begin
			drank_c = drank_c + $signed({2'b00, n_c});
		end
		swap_c = (drank_c <<< 1) > $signed({2'b00, n_c});

		walk_done_c = (s_q == a_q) || (CNT_W'(i_q + 11'd1) == n_c);
	end

	// Store address and write selection per step
	always_comb begin
		rd_addr = '0;
		pred_we = 1'b0;
		succ_we = 1'b0;
		rank_we = 1'b0;
		pred_wa = '0;
		succ_wa = '0;
		rank_wa = '0;
		pred_wd = '0;
		succ_wd = '0;
		rank_wd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && command == CMD_LOAD) begin
					pred_we = 1'b1;
					succ_we = 1'b1;
					rank_we = 1'b1;
					pred_wa = AW'(node_idx(first_node));
					succ_wa = AW'(node_idx(first_node));
					rank_wa = AW'(node_idx(first_node));
					pred_wd = entry_pred;
					succ_wd = entry_succ;
					rank_wd = entry_rank;
				end
			end
			S_RD_ADDR, S_T1: rd_addr = AW'(ta_q);
			S_T2:            rd_addr = AW'(tb_q);
			S_T3:            rd_addr = AW'(tc_q);
			S_RK_B:          rd_addr = AW'(b_q);
			S_RK_C:          rd_addr = AW'(c_q);
			S_RK_A:          rd_addr = AW'(a_q);
			S_START:         rd_addr = AW'(c_q);
			S_WALK: begin
				// swap links and write the rank of the current node, fetch the next one
				rd_addr = AW'(node_idx(succ_rd_q));
				pred_we = 1'b1;
				succ_we = 1'b1;
				rank_we = 1'b1;
				pred_wa = AW'(s_q);
				succ_wa = AW'(s_q);
				rank_wa = AW'(s_q);
				pred_wd = succ_rd_q;
				succ_wd = pred_rd_q;
				rank_wd = nr_q[NODE_W-1:0];
			end
			S_LINK1: begin
				succ_we = 1'b1;
				succ_wa = AW'(c_q);
				succ_wd = b_q;
				pred_we = 1'b1;
				pred_wa = AW'(b_q);
				pred_wd = c_q;
			end
			S_LINK2: begin
				succ_we = 1'b1;
				succ_wa = AW'(d_q);
				succ_wd = a_q;
				pred_we = 1'b1;
				pred_wa = AW'(a_q);
				pred_wd = d_q;
			end
			default: ;
		endcase
	end

	// Predecessor store, write-first on a same-address read
	always_ff @(posedge clk) begin
		if (pred_we) begin
			pred_mem[pred_wa] <= pred_wd;
		end
		if (pred_we && pred_wa == rd_addr) begin
			pred_rd_q <= pred_wd;
		end else begin
			pred_rd_q <= pred_mem[rd_addr];
		end
	end

	// Successor store
	always_ff @(posedge clk) begin
		if (succ_we) begin
			succ_mem[succ_wa] <= succ_wd;
		end
		if (succ_we && succ_wa == rd_addr) begin
			succ_rd_q <= succ_wd;
		end else begin
			succ_rd_q <= succ_mem[rd_addr];
		end
	end

	// Rank store
	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_wa] <= rank_wd;
		end
		if (rank_we && rank_wa == rd_addr) begin
			rank_rd_q <= rank_wd;
		end else begin
			rank_rd_q <= rank_mem[rd_addr];
		end
	end

	// Node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 11'd1024;
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			ta_q         <= '0;
			tb_q         <= '0;
			tc_q         <= '0;
			a_q          <= '0;
			b_q          <= '0;
			c_q          <= '0;
			d_q          <= '0;
			p1_q         <= '0;
			s1_q         <= '0;
			rb_q         <= '0;
			s_q          <= '0;
			i_q          <= '0;
			nr_q         <= '0;
			res_status_q <= ST_LOAD;
			rp_q         <= '0;
			rs_q         <= '0;
			rr_q         <= '0;
			status_q     <= ST_LOAD;
			end_a_q      <= '0;
			end_b_q      <= '0;
			end_c_q      <= '0;
			end_d_q      <= '0;
			read_pred_q  <= '0;
			read_succ_q  <= '0;
			read_rank_q  <= '0;
		end else begin
			// drop the result once transferred, unless a new one takes its place
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ta_q <= node_idx(first_node);
						tb_q <= node_idx(second_node);
						tc_q <= node_idx(third_node);
						case (command)
							CMD_LOAD: begin
								res_status_q <= ST_LOAD;
								state_q      <= S_DONE;
							end
							CMD_FLIP: state_q <= S_T1;
							CMD_READ: state_q <= S_RD_ADDR;
							default:  ;
						endcase
					end
				end
				S_RD_ADDR: state_q <= S_RD_DATA;
				S_RD_DATA: begin
					rp_q         <= pred_rd_q;
					rs_q         <= succ_rd_q;
					rr_q         <= rank_rd_q;
					res_status_q <= ST_READ;
					state_q      <= S_DONE;
				end
				S_T1: state_q <= S_T2;
				S_T2: begin
					p1_q    <= node_idx(pred_rd_q);
					s1_q    <= node_idx(succ_rd_q);
					state_q <= S_T3;
				end
				S_T3: begin
					if (!adj_c) begin
						res_status_q <= ST_NOT_ADJ;
						state_q      <= S_DONE;
					end else if (noop_c) begin
						res_status_q <= ST_NOOP;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_T4;
					end
				end
				S_T4: begin
					// orient so that b follows a
					if (s1_q == tb_q) begin
						a_q <= ta_q;
						b_q <= tb_q;
						c_q <= tc_q;
						d_q <= t4_c;
					end else begin
						a_q <= tb_q;
						b_q <= ta_q;
						c_q <= t4_c;
						d_q <= tc_q;
					end
					state_q <= S_RK_B;
				end
				S_RK_B: state_q <= S_RK_C;
				S_RK_C: begin
					rb_q    <= rank_rd_q;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// reverse the other side if this one is the longer
					if (swap_c) begin
						b_q <= c_q;
						c_q <= b_q;
						a_q <= d_q;
						d_q <= a_q;
					end
					state_q <= S_RK_A;
				end
				S_RK_A: state_q <= S_START;
				S_START: begin
					nr_q    <= {1'b0, rank_rd_q};
					s_q     <= c_q;
					i_q     <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (walk_done_c) begin
						state_q <= S_LINK1;
					end else begin
						s_q  <= node_idx(succ_rd_q);
						i_q  <= CNT_W'(i_q + 11'd1);
						nr_q <= (nr_q == '0) ? CNT_W'(n_c - 11'd1) : CNT_W'(nr_q - 11'd1);
					end
				end
				S_LINK1: state_q <= S_LINK2;
				S_LINK2: begin
					res_status_q <= ST_FLIP_DONE;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						end_a_q     <= (res_status_q == ST_FLIP_DONE) ? a_q : '0;
						end_b_q     <= (res_status_q == ST_FLIP_DONE) ? b_q : '0;
						end_c_q     <= (res_status_q == ST_FLIP_DONE) ? c_q : '0;
						end_d_q     <= (res_status_q == ST_FLIP_DONE) ? d_q : '0;
						read_pred_q <= (res_status_q == ST_READ) ? rp_q : '0;
						read_succ_q <= (res_status_q == ST_READ) ? rs_q : '0;
						read_rank_q <= (res_status_q == ST_READ) ? rr_q : '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign end_a     = end_a_q;
	assign end_b     = end_b_q;
	assign end_c     = end_c_q;
	assign end_d     = end_d_q;
	assign read_pred = read_pred_q;
	assign read_succ = read_succ_q;
	assign read_rank = read_rank_q;

endmodule
